/* rtl/swt_pkg.sv */
// Shared types and constants for the sleep / wake-up timer table.
// No dependencies; every other file of the block apart from swt_ram imports this package.
`default_nettype none

package swt_pkg;

  // Width of a tick count and the value that means "nothing pending"
  localparam int unsigned TIME_W = 63;

  typedef logic [TIME_W-1:0] tick_t;

  localparam tick_t TIME_MAX = '1;

  // Command codes of an input item
  typedef enum logic {
    CMD_SLEEP = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  // Flag bits of one result item, handed from the sequencer to the output stage
  typedef struct packed {
    logic woken_valid;
    logic last_of_run;
    logic status;
  } res_flags_t;

endpackage

`default_nettype wire

/* rtl/swt_in_if.sv */
// Input channel of the timer table: valid/ready handshake plus one command item.
// Depends on swt_pkg for the tick width.
`default_nettype none

interface swt_in_if #(
  parameter int unsigned ID_WIDTH = 8
);
  import swt_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [ID_WIDTH-1:0] task_id;
  tick_t               time_value;

  modport source (output valid, output command, output task_id, output time_value,
                  input ready);
  modport sink   (input valid, input command, input task_id, input time_value,
                  output ready);
endinterface

`default_nettype wire

/* rtl/swt_out_if.sv */
// Result channel of the timer table: valid/ready handshake plus one result item.
// Depends on swt_pkg for the tick width.
`default_nettype none

interface swt_out_if #(
  parameter int unsigned ID_WIDTH = 8
);
  import swt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] woken_id;
  logic                woken_valid;
  logic                last_of_run;
  logic                status;
  tick_t               earliest_wake;

  modport source (output valid, output woken_id, output woken_valid, output last_of_run,
                  output status, output earliest_wake, input ready);
  modport sink   (input valid, input woken_id, input woken_valid, input last_of_run,
                  input status, input earliest_wake, output ready);
endinterface

`default_nettype wire

/* rtl/swt_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module swt_ram #(
  parameter  int unsigned DEPTH = 16,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/swt_ctrl.sv */
// Sequencer of the timer table: appends sleeps, walks and compacts the entry RAM on a
// tick, queues woken ids and replays them as results. Depends on swt_pkg.
`default_nettype none

module swt_ctrl #(
  parameter  int unsigned TABLE_DEPTH = 16,
  parameter  int unsigned ID_WIDTH    = 8,
  localparam int unsigned AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned EW          = swt_pkg::TIME_W + ID_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input item
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [ID_WIDTH-1:0]   in_task_id,
  input  wire swt_pkg::tick_t        in_time_value,
  // entry RAM
  output logic                       ent_we,
  output logic [AW-1:0]              ent_waddr,
  output logic [EW-1:0]              ent_wdata,
  output logic                       ent_re,
  output logic [AW-1:0]              ent_raddr,
  input  wire logic [EW-1:0]         ent_rdata,
  // woken-id queue RAM
  output logic                       q_we,
  output logic [AW-1:0]              q_waddr,
  output logic [ID_WIDTH-1:0]        q_wdata,
  output logic                       q_re,
  output logic [AW-1:0]              q_raddr,
  input  wire logic [ID_WIDTH-1:0]   q_rdata,
  // result to the output stage
  input  wire logic                  res_free,
  output logic                       res_load,
  output logic [ID_WIDTH-1:0]        res_id,
  output swt_pkg::res_flags_t        res_flags,
  output swt_pkg::tick_t             res_earliest
);
  import swt_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  state_e        state_r,    state_nxt;
  logic [CW-1:0] count_r,    count_nxt;
  tick_t         earliest_r, earliest_nxt;
  tick_t         tick_r,     tick_nxt;
  tick_t         min_r,      min_nxt;
  logic [CW-1:0] rd_idx_r,   rd_idx_nxt;
  logic [CW-1:0] keep_r,     keep_nxt;
  logic [CW-1:0] nw_r,       nw_nxt;
  logic [CW-1:0] j_r,        j_nxt;
  logic          pend_r,     pend_nxt;

  logic          accept;
  tick_t         ent_tick;
  logic [ID_WIDTH-1:0] ent_id;
  logic          none_woken;
  logic          is_last;
  logic [CW-1:0] j_inc;

  assign accept     = in_valid && in_ready;
  assign ent_tick   = ent_rdata[EW-1:ID_WIDTH];
  assign ent_id     = ent_rdata[ID_WIDTH-1:0];
  assign none_woken = (nw_r == '0);
  assign j_inc      = j_r + ONE_C;
  assign is_last    = none_woken || (j_inc == nw_r);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      earliest_r <= TIME_MAX;
      rd_idx_r   <= '0;
      keep_r     <= '0;
      nw_r       <= '0;
      j_r        <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      earliest_r <= earliest_nxt;
      rd_idx_r   <= rd_idx_nxt;
      keep_r     <= keep_nxt;
      nw_r       <= nw_nxt;
      j_r        <= j_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Walk payload registers
  always_ff @(posedge clk) begin
    tick_r <= tick_nxt;
    min_r  <= min_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    earliest_nxt = earliest_r;
    tick_nxt     = tick_r;
    min_nxt      = min_r;
    rd_idx_nxt   = rd_idx_r;
    keep_nxt     = keep_r;
    nw_nxt       = nw_r;
    j_nxt        = j_r;
    pend_nxt     = pend_r;

    in_ready     = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = count_r[AW-1:0];
    ent_wdata    = {in_time_value, in_task_id};
    ent_re       = 1'b0;
    ent_raddr    = rd_idx_r[AW-1:0];
    q_we         = 1'b0;
    q_waddr      = nw_r[AW-1:0];
    q_wdata      = ent_id;
    q_re         = 1'b0;
    q_raddr      = j_r[AW-1:0];
    res_load     = 1'b0;
    res_id       = '0;
    res_flags    = '{woken_valid: 1'b0, last_of_run: 1'b1, status: 1'b0};
    res_earliest = earliest_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = res_free;
        if (accept) begin
          if (in_command == CMD_SLEEP) begin
            // Append the entry, or refuse when the table is full
            res_load = 1'b1;
            if (count_r >= DEPTH_C) begin
              res_flags.status = 1'b1;
            end else begin
              ent_we    = 1'b1;
              count_nxt = count_r + ONE_C;
              if (in_time_value < earliest_r) begin
                earliest_nxt = in_time_value;
              end
              res_earliest = earliest_nxt;
            end
          end else begin
            // Start the walk over the table
            tick_nxt   = in_time_value;
            min_nxt    = TIME_MAX;
            rd_idx_nxt = '0;
            keep_nxt   = '0;
            nw_nxt     = '0;
            pend_nxt   = 1'b0;
            state_nxt  = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // Retire the entry read last cycle: queue its id or compact it down
        if (pend_r) begin
          if (ent_tick <= tick_r) begin
            q_we   = 1'b1;
            nw_nxt = nw_r + ONE_C;
          end else begin
            ent_we    = 1'b1;
            ent_waddr = keep_r[AW-1:0];
            ent_wdata = ent_rdata;
            keep_nxt  = keep_r + ONE_C;
            if (ent_tick < min_r) begin
              min_nxt = ent_tick;
            end
          end
        end
        // Issue the next read
        if (rd_idx_r < count_r) begin
          ent_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + ONE_C;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // Close the walk once every entry is retired
        if (!pend_r && (rd_idx_r == count_r)) begin
          count_nxt    = keep_r;
          earliest_nxt = min_r;
          j_nxt        = '0;
          state_nxt    = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        q_re      = 1'b1;
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        // Hand one woken id (or the empty result) to the output stage
        if (res_free) begin
          res_load              = 1'b1;
          res_id                = none_woken ? '0 : q_rdata;
          res_flags.woken_valid = !none_woken;
          res_flags.last_of_run = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_inc;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds table depth");

  a_walk_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |->
      (({1'b0, keep_r} + {1'b0, nw_r} + (CW+1)'(pend_r)) == {1'b0, rd_idx_r}))
    else $error("walk lost or duplicated an entry");

  a_keep_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (keep_r <= rd_idx_r))
    else $error("compaction write overtook the read pointer");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> res_free)
    else $error("result loaded into an occupied output stage");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD && !none_woken) |-> (j_r < nw_r))
    else $error("replay index beyond woken count");
`endif

endmodule

`default_nettype wire

/* rtl/sleep_wakeup_timer_table_top.sv */
// Top level of the sleep / wake-up timer table: sequencer, entry RAM, woken-id queue
// and the output register. Depends on swt_pkg, swt_in_if, swt_out_if, swt_ram, swt_ctrl.
//
// The block keeps up to TABLE_DEPTH sleeping tasks (id plus wake tick) in insertion
// order in a single-port-read entry RAM. A sleep item returns one result; when the
// table is full it is refused with status 1. A tick item walks the table one entry per
// cycle through the entry RAM's read port, compacting survivors in place and queueing
// woken ids, then replays the queue: each id is read from the queue RAM and then loaded
// into the output register, waiting while that register is occupied. Every result of a
// tick carries the earliest pending wake tick after the tick, all ones when the table is
// empty. The output register holds the last result; the next item is taken once that
// result has left, or in the cycle in which it is taken.
`default_nettype none

module sleep_wakeup_timer_table_top #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  swt_in_if.sink    in_if,
  swt_out_if.source out_if
);
  import swt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EW = TIME_W + ID_WIDTH;

  logic                ent_we, ent_re;
  logic [AW-1:0]       ent_waddr, ent_raddr;
  logic [EW-1:0]       ent_wdata, ent_rdata;
  logic                q_we, q_re;
  logic [AW-1:0]       q_waddr, q_raddr;
  logic [ID_WIDTH-1:0] q_wdata, q_rdata;

  logic                res_free, res_load;
  logic [ID_WIDTH-1:0] res_id;
  res_flags_t          res_flags;
  tick_t               res_earliest;

  logic                out_valid_r;
  logic [ID_WIDTH-1:0] out_id_r;
  res_flags_t          out_flags_r;
  tick_t               out_earliest_r;

  swt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_command    (in_if.command),
    .in_task_id    (in_if.task_id),
    .in_time_value (in_if.time_value),
    .ent_we        (ent_we),
    .ent_waddr     (ent_waddr),
    .ent_wdata     (ent_wdata),
    .ent_re        (ent_re),
    .ent_raddr     (ent_raddr),
    .ent_rdata     (ent_rdata),
    .q_we          (q_we),
    .q_waddr       (q_waddr),
    .q_wdata       (q_wdata),
    .q_re          (q_re),
    .q_raddr       (q_raddr),
    .q_rdata       (q_rdata),
    .res_free      (res_free),
    .res_load      (res_load),
    .res_id        (res_id),
    .res_flags     (res_flags),
    .res_earliest  (res_earliest)
  );

  // Entry table: {wake tick, task id} per slot
  swt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Woken ids of the current tick, in table order
  swt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ID_WIDTH)
  ) u_wake_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Output register: free when empty or being taken this cycle
  assign res_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result payload until the next load
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_id_r       <= res_id;
      out_flags_r    <= res_flags;
      out_earliest_r <= res_earliest;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.woken_id      = out_id_r;
  assign out_if.woken_valid   = out_flags_r.woken_valid;
  assign out_if.last_of_run   = out_flags_r.last_of_run;
  assign out_if.status        = out_flags_r.status;
  assign out_if.earliest_wake = out_earliest_r;

endmodule

`default_nettype wire

/* tb/sv/sleep_wakeup_timer_table_checker.sv */
// Scoreboard for the sleep / wake-up timer table: watches both channels, predicts each result.
// Depends on swt_pkg for the tick type, the command codes and the all-ones tick value.
`timescale 1ns / 100ps

module sleep_wakeup_timer_table_checker #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_command,
  input  logic [ID_WIDTH-1:0] in_task_id,
  input  swt_pkg::tick_t      in_time_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [ID_WIDTH-1:0] out_woken_id,
  input  logic                out_woken_valid,
  input  logic                out_last_of_run,
  input  logic                out_status,
  input  swt_pkg::tick_t      out_earliest_wake,
  output int                  fail_count,
  output int                  pending_results
);
  import swt_pkg::*;

  typedef struct packed {
    logic [ID_WIDTH-1:0] woken_id;
    logic                woken_valid;
    logic                last_of_run;
    logic                status;
    tick_t               earliest_wake;
  } wake_result_t;

  // Shadow copy of the sleeper table, kept in insertion order
  tick_t               wake_tab  [TABLE_DEPTH];
  logic [ID_WIDTH-1:0] owner_tab [TABLE_DEPTH];
  int unsigned         sleeper_count    = 0;
  tick_t               earliest_pending = TIME_MAX;
  wake_result_t        due_results[$];
  int                  bad_results      = 0;

  function automatic wake_result_t make_result(input logic [ID_WIDTH-1:0] id,
                                               input logic woken, input logic last,
                                               input logic refused);
    wake_result_t r;
    r.woken_id      = id;
    r.woken_valid   = woken;
    r.last_of_run   = last;
    r.status        = refused;
    r.earliest_wake = earliest_pending;
    return r;
  endfunction

  // Apply one command item to the shadow table and queue the results it causes
  task automatic apply_timer_item(input cmd_e cmd, input logic [ID_WIDTH-1:0] id,
                                  input tick_t t);
    logic [ID_WIDTH-1:0] woken[$];
    int unsigned         kept;
    tick_t               lowest;
    if (cmd == CMD_SLEEP) begin
      if (sleeper_count >= TABLE_DEPTH) begin
        // table full: refuse, leave everything as it is
        due_results.push_back(make_result('0, 1'b0, 1'b1, 1'b1));
      end else begin
        wake_tab[sleeper_count]  = t;
        owner_tab[sleeper_count] = id;
        sleeper_count++;
        if (t < earliest_pending) earliest_pending = t;
        due_results.push_back(make_result('0, 1'b0, 1'b1, 1'b0));
      end
    end else begin
      // walk in insertion order, wake due entries, compact the survivors
      kept   = 0;
      lowest = TIME_MAX;
      for (int i = 0; i < sleeper_count; i++) begin
        if (wake_tab[i] <= t) begin
          woken.push_back(owner_tab[i]);
        end else begin
          wake_tab[kept]  = wake_tab[i];
          owner_tab[kept] = owner_tab[i];
          if (wake_tab[i] < lowest) lowest = wake_tab[i];
          kept++;
        end
      end
      sleeper_count    = kept;
      earliest_pending = lowest;
      if (woken.size() == 0) begin
        due_results.push_back(make_result('0, 1'b0, 1'b1, 1'b0));
      end else begin
        foreach (woken[i])
          due_results.push_back(make_result(woken[i], 1'b1, i == woken.size() - 1, 1'b0));
      end
    end
  endtask

  // Predict on accepted inputs, compare accepted results against the oldest expectation
  always @(posedge clk) begin
    wake_result_t want;
    wake_result_t got;
    if (!rst_n) begin
      sleeper_count    = 0;
      earliest_pending = TIME_MAX;
      due_results.delete();
    end else begin
      if (in_valid && in_ready)
        apply_timer_item(cmd_e'(in_command), in_task_id, in_time_value);
      if (out_valid && out_ready) begin
        got.woken_id      = out_woken_id;
        got.woken_valid   = out_woken_valid;
        got.last_of_run   = out_last_of_run;
        got.status        = out_status;
        got.earliest_wake = out_earliest_wake;
        if (due_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: unexpected result id=%0h woken=%b last=%b status=%b earliest=%0h",
                     $realtime, got.woken_id, got.woken_valid, got.last_of_run, got.status,
                     got.earliest_wake);
        end else begin
          want = due_results.pop_front();
          if (got.woken_id !== want.woken_id || got.woken_valid !== want.woken_valid ||
              got.last_of_run !== want.last_of_run || got.status !== want.status ||
              got.earliest_wake !== want.earliest_wake) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected id=%0h woken=%b last=%b status=%b earliest=%0h",
                       want.woken_id, want.woken_valid, want.last_of_run, want.status,
                       want.earliest_wake);
              $display("  actual   id=%0h woken=%b last=%b status=%b earliest=%0h",
                       got.woken_id, got.woken_valid, got.last_of_run, got.status,
                       got.earliest_wake);
            end
          end
        end
      end
    end
    pending_results <= due_results.size();
    fail_count      <= bad_results;
  end

endmodule

/* tb/sv/sleep_wakeup_timer_table_top_tb.sv */
// Testbench top for the sleep / wake-up timer table: clock, reset, item stimulus, verdict.
// Depends on swt_pkg, swt_in_if, swt_out_if, the block and sleep_wakeup_timer_table_checker.
`timescale 1ns / 100ps

module sleep_wakeup_timer_table_top_tb;
  import swt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ID_WIDTH    = 8;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  bit   steady_flow = 1'b0;

  swt_in_if  #(.ID_WIDTH(ID_WIDTH)) in_ch ();
  swt_out_if #(.ID_WIDTH(ID_WIDTH)) out_ch ();

  sleep_wakeup_timer_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  sleep_wakeup_timer_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_command       (in_ch.command),
    .in_task_id       (in_ch.task_id),
    .in_time_value    (in_ch.time_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_woken_id     (out_ch.woken_id),
    .out_woken_valid  (out_ch.woken_valid),
    .out_last_of_run  (out_ch.last_of_run),
    .out_status       (out_ch.status),
    .out_earliest_wake(out_ch.earliest_wake),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic tick_t random_tick();
    return tick_t'({$urandom, $urandom});
  endfunction

  // Offer one item after a random gap; return at the falling edge after it is taken
  task automatic send_item(input cmd_e cmd, input logic [ID_WIDTH-1:0] id, input tick_t t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.task_id    <= id;
    in_ch.time_value <= t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Result side: stall a random number of cycles before taking each result
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    tick_t clock_now;
    tick_t t;
    int    roll;
    int    waited;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_SLEEP;
    in_ch.task_id    = '0;
    in_ch.time_value = '0;
    rst_n            = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tick, wake at equal tick, nothing due, past-due sleep
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_SLEEP, 8'h00, '0);
    send_item(CMD_SLEEP, 8'hFF, TIME_MAX);
    send_item(CMD_TICK, 8'hFF, '0);
    send_item(CMD_TICK, '0, TIME_MAX - 1);
    send_item(CMD_SLEEP, 8'h5A, tick_t'(2));
    send_item(CMD_TICK, '0, tick_t'(2));

    // Directed: fill the table, get refused, then wake everything in one tick
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      send_item(CMD_SLEEP, ID_WIDTH'($urandom), tick_t'($urandom_range(1, 1000)));
    send_item(CMD_SLEEP, 8'hA5, '0);
    send_item(CMD_TICK, '0, TIME_MAX);

    // Random: sleeps near a moving current tick, ticks that advance it, some wide jumps
    clock_now = random_tick() >> 1;
    for (int n = 0; n < 96; n++) begin
      if (n % 20 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        case ($urandom_range(0, 9))
          0:       t = random_tick();
          1:       t = clock_now - tick_t'($urandom_range(0, 50));
          default: t = clock_now + tick_t'($urandom_range(1, 300));
        endcase
        send_item(CMD_SLEEP, ID_WIDTH'($urandom), t);
      end else if (roll < 95) begin
        clock_now = clock_now + tick_t'($urandom_range(0, 200));
        send_item(CMD_TICK, ID_WIDTH'($urandom), clock_now);
      end else if (roll < 98) begin
        send_item(CMD_TICK, ID_WIDTH'($urandom), random_tick());
      end else begin
        send_item(CMD_TICK, ID_WIDTH'($urandom), TIME_MAX);
      end
    end
    in_ch.valid <= 1'b0;
    steady_flow = 1'b0;

    // Drain, then watch a while longer for stray results
    waited = 0;
    while (pending_results != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
